// ===== design/pgw_pkg.sv =====
package pgw_pkg;

  localparam int unsigned LEVELS     = 5;
  localparam int unsigned ADDR_BITS  = 52;
  localparam int unsigned VA_BITS    = 44;
  localparam int unsigned IDX_BITS   = 9;
  localparam int unsigned LVL_BITS   = 3;
  localparam int unsigned STEP_BITS  = 3;
  localparam int unsigned ENTRY_BITS = 64;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  localparam logic [LVL_BITS-1:0] LVL_ROOT = 3'd4;
  localparam logic [LVL_BITS-1:0] LVL_WIDE = 3'd1;
  localparam logic [LVL_BITS-1:0] LVL_LEAF = 3'd0;

  localparam logic [1:0] APER_DESCEND = 2'd1;

  localparam logic [1:0] CFG_ROOT_TABLE = 2'd0;
  localparam logic [1:0] CFG_APER_BASE  = 2'd1;
  localparam logic [1:0] CFG_MAX_STEPS  = 2'd2;

  localparam logic [STEP_BITS-1:0] MAX_STEPS_RESET = 3'd5;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_STEP    = 2'd1,
    KIND_REFUSE  = 2'd2
  } kind_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    kind_e                  kind;
    logic [ADDR_BITS-1:0]   address;
    logic [LVL_BITS-1:0]    level;
    logic [IDX_BITS-1:0]    index;
    logic [ENTRY_BITS-1:0]  entry;
    logic [ADDR_BITS-1:0]   next_table;
    logic [1:0]             aperture;
    logic [STEP_BITS-1:0]   step_count;
    logic                   last;
  } result_t;

  typedef struct packed {
    logic                  active;
    logic [LVL_BITS-1:0]   level;
    logic [ADDR_BITS-1:0]  table_addr;
    logic [VA_BITS-1:0]    va_bits;
    logic [STEP_BITS-1:0]  steps;
  } walk_state_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  root_table;
    logic [ADDR_BITS-1:0]  aper_base;
    logic [STEP_BITS-1:0]  max_steps;
  } cfg_t;

  // Index field of the virtual page number for a level; level 1 has 8 bits.
  function automatic logic [IDX_BITS-1:0] index_at(logic [LVL_BITS-1:0] lvl,
                                                   logic [VA_BITS-1:0] va);
    logic [IDX_BITS-1:0] idx;
    case (lvl)
      3'd0:    idx = va[8:0];
      3'd1:    idx = {1'b0, va[16:9]};
      3'd2:    idx = va[25:17];
      3'd3:    idx = va[34:26];
      3'd4:    idx = va[43:35];
      default: idx = '0;
    endcase
    return idx;
  endfunction

  function automatic result_t make_request(logic [LVL_BITS-1:0] lvl,
                                           logic [ADDR_BITS-1:0] tbl,
                                           logic [VA_BITS-1:0] va,
                                           logic [STEP_BITS-1:0] steps);
    result_t r;
    logic [IDX_BITS-1:0] idx;
    logic [ADDR_BITS-1:0] off;
    idx = index_at(lvl, va);
    // 16-byte entries at level 1, upper half read
    if (lvl == LVL_WIDE) begin
      off = {39'd0, idx, 4'd0} + 52'd8;
    end else begin
      off = {40'd0, idx, 3'd0};
    end
    r            = '0;
    r.kind       = KIND_REQUEST;
    r.address    = tbl + off;
    r.level      = lvl;
    r.index      = idx;
    r.step_count = steps;
    return r;
  endfunction

endpackage

// ===== design/five_level_page_table_walker.sv =====
// A transaction's results (none for a read with no walk open, two for a
// step that descends, else one) are written into the 4-entry result queue
// as it is accepted and leave the queue in order. Throughput: one input
// transaction per cycle while the queue has room for two; results leave at
// one per cycle while the sink is ready. Reset clears the walk and queue and
// puts the configuration at root 0, aperture base 0, max steps 5.
module five_level_page_table_walker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [55:0] virtual_address, [56] window_alive, [120:57] read_data, rest zero
  input  logic [127:0]  s_axis_tdata,
  // [0] operation
  input  logic [0:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [51:0] address, [54:52] level, [63:55] index, [127:64] entry,
  // [179:128] next_table, [181:180] aperture, [184:182] step_count, rest zero
  output logic [191:0]  m_axis_tdata,
  // [1:0] kind
  output logic [1:0]    m_axis_tuser,
  output logic          m_axis_tlast,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [63:0]   cfg_data_i
);

  pgw_pkg::cfg_t        cfg_q, cfg_d;
  pgw_pkg::walk_state_t st_q, st_d;
  pgw_pkg::result_t     res0, res1, head;
  logic [1:0]           n_res;
  logic                 accept, room2, cfg_we;

  assign s_axis_tready = room2;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      case (cfg_index_i)
        pgw_pkg::CFG_ROOT_TABLE: cfg_d.root_table = cfg_data_i[pgw_pkg::ADDR_BITS-1:0];
        pgw_pkg::CFG_APER_BASE:  cfg_d.aper_base  = cfg_data_i[pgw_pkg::ADDR_BITS-1:0];
        pgw_pkg::CFG_MAX_STEPS:  cfg_d.max_steps  = cfg_data_i[pgw_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  pgw_step u_step (
    .accept_i (accept),
    .op_i     (pgw_pkg::op_e'(s_axis_tuser[0])),
    .va_i     (s_axis_tdata[55:0]),
    .alive_i  (s_axis_tdata[56]),
    .rdata_i  (s_axis_tdata[120:57]),
    .cfg_i    (cfg_q),
    .state_i  (st_q),
    .state_o  (st_d),
    .res0_o   (res0),
    .res1_o   (res1),
    .n_res_o  (n_res)
  );

  pgw_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (n_res),
    .push0_i  (res0),
    .push1_i  (res1),
    .room2_o  (room2),
    .valid_o  (m_axis_tvalid),
    .pop_i    (m_axis_tready),
    .head_o   (head)
  );

  assign m_axis_tdata = {7'd0, head.step_count, head.aperture, head.next_table,
                         head.entry, head.index, head.level, head.address};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_table <= '0;
      cfg_q.aper_base  <= '0;
      cfg_q.max_steps  <= pgw_pkg::MAX_STEPS_RESET;
      st_q             <= '0;
    end else begin
      cfg_q <= cfg_d;
      st_q  <= st_d;
    end
  end

endmodule

// ===== design/pgw_step.sv =====
module pgw_step (
  input  logic                              accept_i,
  input  pgw_pkg::op_e                      op_i,
  input  logic [55:0]                       va_i,
  input  logic                              alive_i,
  input  logic [pgw_pkg::ENTRY_BITS-1:0]    rdata_i,
  input  pgw_pkg::cfg_t                     cfg_i,
  input  pgw_pkg::walk_state_t              state_i,
  output pgw_pkg::walk_state_t              state_o,
  output pgw_pkg::result_t                  res0_o,
  output pgw_pkg::result_t                  res1_o,
  output logic [1:0]                        n_res_o
);

  logic                             start_ok;
  logic [pgw_pkg::VA_BITS-1:0]      va_new;
  logic [pgw_pkg::STEP_BITS-1:0]    steps_new;
  logic [pgw_pkg::ADDR_BITS-1:0]    next_tbl;
  logic [1:0]                       aper;
  logic                             done;
  logic [pgw_pkg::LVL_BITS-1:0]     lvl_down;

  assign va_new    = va_i[55:12];
  assign steps_new = state_i.steps + 3'd1;
  assign next_tbl  = {rdata_i[51:12], 12'd0};
  assign aper      = rdata_i[2:1];
  assign lvl_down  = state_i.level - 3'd1;
  assign done      = (state_i.level == pgw_pkg::LVL_LEAF) ||
                     (aper != pgw_pkg::APER_DESCEND) ||
                     (steps_new >= cfg_i.max_steps);

  assign start_ok = !state_i.active && (cfg_i.root_table != '0) &&
                    (cfg_i.root_table[11:0] == 12'd0) &&
                    (cfg_i.aper_base != '0) && (cfg_i.max_steps != '0) && alive_i;

  always_comb begin
    state_o = state_i;
    res0_o  = '0;
    res1_o  = '0;
    n_res_o = 2'd0;
    if (accept_i) begin
      if (op_i == pgw_pkg::OP_START) begin
        n_res_o = 2'd1;
        if (start_ok) begin
          state_o.active     = 1'b1;
          state_o.level      = pgw_pkg::LVL_ROOT;
          state_o.table_addr = cfg_i.root_table;
          state_o.va_bits    = va_new;
          state_o.steps      = '0;
          res0_o = pgw_pkg::make_request(pgw_pkg::LVL_ROOT, cfg_i.root_table,
                                         va_new, '0);
        end else begin
          res0_o.kind = pgw_pkg::KIND_REFUSE;
          res0_o.last = 1'b1;
        end
      end else if (state_i.active) begin
        n_res_o           = 2'd1;
        res0_o.kind       = pgw_pkg::KIND_STEP;
        res0_o.address    = state_i.table_addr;
        res0_o.level      = state_i.level;
        res0_o.index      = pgw_pkg::index_at(state_i.level, state_i.va_bits);
        res0_o.entry      = rdata_i;
        res0_o.next_table = next_tbl;
        res0_o.aperture   = aper;
        res0_o.step_count = steps_new;
        res0_o.last       = done;
        state_o.steps     = steps_new;
        if (done) begin
          state_o.active = 1'b0;
        end else begin
          n_res_o            = 2'd2;
          state_o.level      = lvl_down;
          state_o.table_addr = next_tbl;
          res1_o = pgw_pkg::make_request(lvl_down, next_tbl, state_i.va_bits,
                                         steps_new);
        end
      end
    end
  end

endmodule

// ===== design/pgw_fifo.sv =====
module pgw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  pgw_pkg::result_t  push0_i,
  input  pgw_pkg::result_t  push1_i,
  output logic              room2_o,
  output logic              valid_o,
  input  logic              pop_i,
  output pgw_pkg::result_t  head_o
);

  pgw_pkg::result_t                  mem [pgw_pkg::FIFO_DEPTH];
  logic [pgw_pkg::FIFO_PTR_BITS-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [pgw_pkg::FIFO_PTR_BITS-1:0] wptr_p1;
  logic [pgw_pkg::FIFO_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                              pop;

  assign pop     = pop_i && valid_o;
  assign wptr_p1 = wptr_q + {{(pgw_pkg::FIFO_PTR_BITS-1){1'b0}}, 1'b1};
  assign wptr_d  = wptr_q + push_n_i;
  assign rptr_d  = rptr_q + {{(pgw_pkg::FIFO_PTR_BITS-1){1'b0}}, pop};
  assign cnt_d   = cnt_q + {{(pgw_pkg::FIFO_CNT_BITS-2){1'b0}}, push_n_i}
                 - {{(pgw_pkg::FIFO_CNT_BITS-1){1'b0}}, pop};

  assign valid_o = cnt_q != '0;
  assign room2_o = cnt_q <= pgw_pkg::FIFO_CNT_BITS'(pgw_pkg::FIFO_DEPTH - 2);
  assign head_o  = mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem[wptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem[wptr_p1] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== sim/tb_five_level_page_table_walker.sv =====
module tb_five_level_page_table_walker;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 2000;

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  // [55:0] virtual_address, [56] window_alive, [120:57] read_data, rest zero
  logic [127:0]  s_axis_tdata;
  // [0] operation
  logic [0:0]    s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  // [51:0] address, [54:52] level, [63:55] index, [127:64] entry,
  // [179:128] next_table, [181:180] aperture, [184:182] step_count, rest zero
  logic [191:0]  m_axis_tdata;
  // [1:0] kind
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          cfg_valid_i;
  logic          cfg_ready_o;
  logic [1:0]    cfg_index_i;
  logic [63:0]   cfg_data_i;

  five_level_page_table_walker dut (.*);

  always #6 clk_i = ~clk_i;

  int src_idle_pct  = 11;
  int sink_idle_pct = 80;
  int mismatch_count = 0;
  int stall_cycles = 0;

  // walker state as predicted by the testbench
  logic [pgw_pkg::ADDR_BITS-1:0] root_cfg   = '0;
  logic [pgw_pkg::ADDR_BITS-1:0] aper_cfg   = '0;
  logic [pgw_pkg::STEP_BITS-1:0] step_limit = pgw_pkg::MAX_STEPS_RESET;
  logic                          walk_on    = 1'b0;
  logic [pgw_pkg::LVL_BITS-1:0]  cur_lvl    = '0;
  logic [pgw_pkg::ADDR_BITS-1:0] cur_tbl    = '0;
  logic [pgw_pkg::VA_BITS-1:0]   va_pages   = '0;
  logic [pgw_pkg::STEP_BITS-1:0] steps      = '0;

  pgw_pkg::result_t pending_results[$];
  pgw_pkg::result_t head_result;

  function automatic logic [63:0] wide_random();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] make_entry(logic [1:0] ap);
    logic [63:0] e;
    e = wide_random();
    e[2:1] = ap;
    return e;
  endfunction

  // index bits sit above the page offset: 9 per level, only 8 at level 1
  function automatic logic [pgw_pkg::IDX_BITS-1:0] walk_index(
      logic [pgw_pkg::LVL_BITS-1:0] lvl, logic [pgw_pkg::VA_BITS-1:0] vpn);
    int unsigned sh;
    logic [pgw_pkg::VA_BITS-1:0] t;
    if (lvl == pgw_pkg::LVL_LEAF) sh = 0;
    else if (lvl == pgw_pkg::LVL_WIDE) sh = 9;
    else sh = 17 + 9 * (int'(lvl) - 2);
    t = vpn >> sh;
    return (lvl == pgw_pkg::LVL_WIDE) ? {1'b0, t[7:0]} : t[8:0];
  endfunction

  function automatic pgw_pkg::result_t read_request();
    pgw_pkg::result_t r;
    logic [pgw_pkg::IDX_BITS-1:0] idx;
    logic [pgw_pkg::ADDR_BITS-1:0] off;
    idx = walk_index(cur_lvl, va_pages);
    if (cur_lvl == pgw_pkg::LVL_WIDE) begin
      off = (pgw_pkg::ADDR_BITS'(idx) << 4) + pgw_pkg::ADDR_BITS'(8);
    end else begin
      off = pgw_pkg::ADDR_BITS'(idx) << 3;
    end
    r = '0;
    r.kind       = pgw_pkg::KIND_REQUEST;
    r.address    = cur_tbl + off;
    r.level      = cur_lvl;
    r.index      = idx;
    r.step_count = steps;
    return r;
  endfunction

  task automatic predict_walk_results(pgw_pkg::op_e op, logic [55:0] va, logic alive,
                                      logic [63:0] rd);
    pgw_pkg::result_t rec;
    logic ends;
    if (op == pgw_pkg::OP_START) begin
      if (walk_on || root_cfg == '0 || root_cfg[11:0] != '0 || aper_cfg == '0 ||
          step_limit == '0 || !alive) begin
        rec = '0;
        rec.kind = pgw_pkg::KIND_REFUSE;
        rec.last = 1'b1;
        pending_results.push_back(rec);
      end else begin
        walk_on  = 1'b1;
        cur_lvl  = pgw_pkg::LVL_ROOT;
        cur_tbl  = root_cfg;
        va_pages = va[55:12];
        steps    = '0;
        pending_results.push_back(read_request());
      end
    end else if (walk_on) begin
      steps = steps + pgw_pkg::STEP_BITS'(1);
      rec = '0;
      rec.kind       = pgw_pkg::KIND_STEP;
      rec.address    = cur_tbl;
      rec.level      = cur_lvl;
      rec.index      = walk_index(cur_lvl, va_pages);
      rec.entry      = rd;
      rec.next_table = {rd[51:12], 12'd0};
      rec.aperture   = rd[2:1];
      rec.step_count = steps;
      ends = (cur_lvl == pgw_pkg::LVL_LEAF) || (rd[2:1] != pgw_pkg::APER_DESCEND) ||
             (steps >= step_limit);
      rec.last = ends;
      pending_results.push_back(rec);
      if (ends) begin
        walk_on = 1'b0;
      end else begin
        cur_lvl = cur_lvl - pgw_pkg::LVL_BITS'(1);
        cur_tbl = rec.next_table;
        pending_results.push_back(read_request());
      end
    end
  endtask

  // tvalid is left high on return; the next call replaces or drops it, drain_results drops it
  task automatic issue_item(pgw_pkg::op_e op, logic [55:0] va, logic alive,
                            logic [63:0] rd);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, rd, alive, va};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_walk_results(op, va, alive, rd);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pgw_pkg::CFG_ROOT_TABLE: root_cfg   = data[pgw_pkg::ADDR_BITS-1:0];
      pgw_pkg::CFG_APER_BASE:  aper_cfg   = data[pgw_pkg::ADDR_BITS-1:0];
      pgw_pkg::CFG_MAX_STEPS:  step_limit = data[pgw_pkg::STEP_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [63:0] root, logic [63:0] aper, logic [63:0] limit);
    write_reg(pgw_pkg::CFG_ROOT_TABLE, root);
    write_reg(pgw_pkg::CFG_APER_BASE, aper);
    write_reg(pgw_pkg::CFG_MAX_STEPS, limit);
    cfg_valid_i <= 1'b0;
  endtask

  // a read with no walk yields nothing, so keep waiting past the last result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_start_refusals();
    issue_item(pgw_pkg::OP_START, '0, 1'b1, '0);
    drain_results();
    set_regs(64'h1234_5800, 64'd1, 64'd5);
    issue_item(pgw_pkg::OP_START, '1, 1'b1, '0);
    drain_results();
    set_regs(64'h1000, 64'd0, 64'd5);
    issue_item(pgw_pkg::OP_START, '0, 1'b1, '0);
    drain_results();
    set_regs(64'h1000, '1, 64'd0);
    issue_item(pgw_pkg::OP_START, '0, 1'b1, '0);
    drain_results();
    set_regs(64'h1000, 64'd1, 64'd5);
    issue_item(pgw_pkg::OP_START, 56'h55_5555_5555_5555, 1'b0, '1);
    issue_item(pgw_pkg::OP_READ, '1, 1'b1, '1);
    drain_results();
  endtask

  task automatic test_deep_walk();
    // bits above the register width are dropped by the block
    set_regs(64'hFFFF_FFFF_FFFF_F000, '1, 64'd7);
    issue_item(pgw_pkg::OP_START, '1, 1'b1, '0);
    issue_item(pgw_pkg::OP_READ, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFB);
    issue_item(pgw_pkg::OP_START, 56'h12_3456_789A_BCDE, 1'b1, '0);
    repeat (3) issue_item(pgw_pkg::OP_READ, '0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFB);
    issue_item(pgw_pkg::OP_READ, '0, 1'b0, '1);
    drain_results();
  endtask

  task automatic test_aperture_codes();
    logic [1:0] ends_walk [3] = '{2'd0, 2'd2, 2'd3};
    set_regs(64'h8000_0000, 64'h1_0000, 64'd5);
    foreach (ends_walk[i]) begin
      issue_item(pgw_pkg::OP_START, 56'(wide_random()), 1'b1, '0);
      issue_item(pgw_pkg::OP_READ, '0, 1'b1,
                 (i == 0) ? 64'd0 : make_entry(ends_walk[i]));
    end
    drain_results();
  endtask

  task automatic test_step_limit();
    set_regs(64'h4_0000_0000, 64'h2000, 64'd2);
    issue_item(pgw_pkg::OP_START, 56'(wide_random()), 1'b1, '0);
    repeat (2) issue_item(pgw_pkg::OP_READ, '0, 1'b1, make_entry(pgw_pkg::APER_DESCEND));
    drain_results();
    // reopen a walk, then lower the limit while it is still open
    set_regs(64'h4_0000_0000, 64'h2000, 64'd5);
    issue_item(pgw_pkg::OP_START, 56'(wide_random()), 1'b1, '0);
    issue_item(pgw_pkg::OP_READ, '0, 1'b1, make_entry(pgw_pkg::APER_DESCEND));
    drain_results();
    write_reg(pgw_pkg::CFG_MAX_STEPS, 64'd1);
    write_reg(CFG_UNUSED, wide_random());
    cfg_valid_i <= 1'b0;
    issue_item(pgw_pkg::OP_READ, '0, 1'b1, make_entry(pgw_pkg::APER_DESCEND));
    drain_results();
  endtask

  task automatic run_random(int count);
    int sent;
    int since_cfg;
    int r;
    sent = 0;
    since_cfg = 0;
    while (sent < count) begin
      if (since_cfg == 75) begin
        drain_results();
        set_regs(wide_random() & ~64'hFFF, wide_random(),
                 (wide_random() & ~64'h7) | 64'($urandom_range(1, 7)));
        since_cfg = 0;
      end
      r = $urandom_range(99);
      if (!walk_on) begin
        if (r < 88) begin
          issue_item(pgw_pkg::OP_START, 56'(wide_random()), $urandom_range(19) != 0,
                     wide_random());
          sent++;
          since_cfg++;
        end else if (r < 94) begin
          // no walk running: dropped by the block, not counted
          issue_item(pgw_pkg::OP_READ, 56'(wide_random()), 1'($urandom_range(1)),
                     wide_random());
        end else begin
          issue_item(pgw_pkg::OP_START, 56'(wide_random()), 1'b0, wide_random());
          sent++;
          since_cfg++;
        end
      end else begin
        if (r < 92)
          issue_item(pgw_pkg::OP_READ, 56'(wide_random()), 1'($urandom_range(1)),
                     make_entry(($urandom_range(99) < 85) ? pgw_pkg::APER_DESCEND
                                                         : 2'($urandom_range(3))));
        else
          issue_item(pgw_pkg::OP_START, 56'(wide_random()), 1'b1, wide_random());
        sent++;
        since_cfg++;
      end
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    set_regs(64'h0000_0001_2345_6000, 64'h0000_0000_8000_0000, 64'd5);
    run_random(300);
    src_idle_pct  = 80;
    sink_idle_pct = 11;
    set_regs(wide_random() & ~64'hFFF, '1, 64'd3);
    run_random(300);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_regs(wide_random() & ~64'hFFF, wide_random(), 64'd7);
    run_random(300);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation: kind %0d", m_axis_tuser);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        check_field("kind", 64'(head_result.kind), 64'(m_axis_tuser));
        check_field("address", 64'(head_result.address), 64'(m_axis_tdata[51:0]));
        check_field("level", 64'(head_result.level), 64'(m_axis_tdata[54:52]));
        check_field("index", 64'(head_result.index), 64'(m_axis_tdata[63:55]));
        check_field("entry", head_result.entry, m_axis_tdata[127:64]);
        check_field("next_table", 64'(head_result.next_table),
                    64'(m_axis_tdata[179:128]));
        check_field("aperture", 64'(head_result.aperture), 64'(m_axis_tdata[181:180]));
        check_field("step_count", 64'(head_result.step_count),
                    64'(m_axis_tdata[184:182]));
        check_field("last", 64'(head_result.last), 64'(m_axis_tlast));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_start_refusals();
    test_deep_walk();
    test_aperture_codes();
    test_step_limit();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
